>>> hw/rtl/ccc_pkg.sv
// ============================================================================
// ccc_pkg: shared types and constants for the calendar clock counter
// Calendar limits, month-length table, command codes and the time record.
// ============================================================================
package ccc_pkg;

    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int FUNC_W  = 2;

    localparam logic [SEC_W-1:0]   MAX_SECOND = SEC_W'(59);
    localparam logic [MIN_W-1:0]   MAX_MINUTE = MIN_W'(59);
    localparam logic [HOUR_W-1:0]  MAX_HOUR   = HOUR_W'(23);
    localparam logic [MONTH_W-1:0] MONTHS     = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   LONG_MONTH = DAY_W'(31);

    // Month lengths, no leap years.
    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        DAY_W'(31), DAY_W'(28), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30),
        DAY_W'(31), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30), DAY_W'(31)
    };

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK      = 2'd0,
        FUNC_LOAD_ALL  = 2'd1,
        FUNC_LOAD_DATE = 2'd2
    } func_t;

    typedef struct packed {
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } cal_time_t;

    typedef struct packed {
        cal_time_t tm;
        logic      time_valid;
        logic      minute_event;
    } step_res_t;

    localparam cal_time_t RESET_TIME = '{
        second: '0, minute: '0, hour: '0,
        day: DAY_W'(1), month: MONTH_W'(1), year: '0
    };

    // Out-of-range months count as 31 days.
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month);
        logic [MONTH_W-1:0] idx;
        idx = month - MONTH_W'(1);
        if (month >= MONTH_W'(1) && month <= MONTHS)
        begin
            return MONTH_LEN[idx];
        end
        return LONG_MONTH;
    endfunction

endpackage

>>> hw/rtl/ccc_if.sv
// ============================================================================
// ccc_if: request and response channels of the calendar clock counter
// Valid/ready channels; a word moves when valid and ready are both high.
// ============================================================================
interface ccc_req_if;
    logic                        valid;
    logic                        ready;
    logic [ccc_pkg::FUNC_W-1:0]  func;
    logic [ccc_pkg::SEC_W-1:0]   set_second;
    logic [ccc_pkg::MIN_W-1:0]   set_minute;
    logic [ccc_pkg::HOUR_W-1:0]  set_hour;
    logic [ccc_pkg::DAY_W-1:0]   set_day;
    logic [ccc_pkg::MONTH_W-1:0] set_month;
    logic [ccc_pkg::YEAR_W-1:0]  set_year;

    modport source (
        output valid, func, set_second, set_minute, set_hour, set_day, set_month,
               set_year,
        input  ready
    );
    modport sink (
        input  valid, func, set_second, set_minute, set_hour, set_day, set_month,
               set_year,
        output ready
    );
endinterface

interface ccc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ccc_pkg::SEC_W-1:0]   cur_second;
    logic [ccc_pkg::MIN_W-1:0]   cur_minute;
    logic [ccc_pkg::HOUR_W-1:0]  cur_hour;
    logic [ccc_pkg::DAY_W-1:0]   cur_day;
    logic [ccc_pkg::MONTH_W-1:0] cur_month;
    logic [ccc_pkg::YEAR_W-1:0]  cur_year;
    logic                        time_valid;
    logic                        minute_event;

    modport source (
        output valid, cur_second, cur_minute, cur_hour, cur_day, cur_month,
               cur_year, time_valid, minute_event,
        input  ready
    );
    modport sink (
        input  valid, cur_second, cur_minute, cur_hour, cur_day, cur_month,
               cur_year, time_valid, minute_event,
        output ready
    );
endinterface

>>> hw/rtl/ccc_step.sv
// ============================================================================
// ccc_step: next-time logic of the calendar clock counter
// Applies one command to the current time: tick with carry chain, or load.
// ============================================================================
module ccc_step (
    input  ccc_pkg::cal_time_t          cur,
    input  logic                        fast_mode,
    input  logic [ccc_pkg::FUNC_W-1:0]  func,
    input  ccc_pkg::cal_time_t          load,
    output ccc_pkg::step_res_t          res
);

    logic [ccc_pkg::SEC_W:0]   sec_inc;
    logic [ccc_pkg::MIN_W:0]   min_inc;
    logic [ccc_pkg::HOUR_W:0]  hour_inc;
    logic [ccc_pkg::DAY_W:0]   day_inc;
    logic [ccc_pkg::MONTH_W:0] month_inc;
    logic                      sec_wrap;
    logic                      adv_min;
    logic                      c_hour;
    logic                      c_day;
    logic                      c_month;
    logic                      c_year;
    ccc_pkg::cal_time_t        ticked;
    ccc_pkg::cal_time_t        nxt;
    logic                      tick;

    // Increments carry one extra bit so out-of-range loads roll over.
    assign sec_inc   = {1'b0, cur.second} + 1'b1;
    assign min_inc   = {1'b0, cur.minute} + 1'b1;
    assign hour_inc  = {1'b0, cur.hour} + 1'b1;
    assign day_inc   = {1'b0, cur.day} + 1'b1;
    assign month_inc = {1'b0, cur.month} + 1'b1;

    assign sec_wrap = sec_inc > {1'b0, ccc_pkg::MAX_SECOND};
    assign adv_min  = fast_mode || sec_wrap;
    assign c_hour   = adv_min && (min_inc > {1'b0, ccc_pkg::MAX_MINUTE});
    assign c_day    = c_hour && (hour_inc > {1'b0, ccc_pkg::MAX_HOUR});
    assign c_month  = c_day && (day_inc > {1'b0, ccc_pkg::days_in(cur.month)});
    assign c_year   = c_month && (month_inc > {1'b0, ccc_pkg::MONTHS});

    always_comb
    begin
        ticked = cur;
        if (!fast_mode)
        begin
            ticked.second = sec_wrap ? '0 : sec_inc[ccc_pkg::SEC_W-1:0];
        end
        if (adv_min)
        begin
            ticked.minute = c_hour ? '0 : min_inc[ccc_pkg::MIN_W-1:0];
        end
        if (c_hour)
        begin
            ticked.hour = c_day ? '0 : hour_inc[ccc_pkg::HOUR_W-1:0];
        end
        if (c_day)
        begin
            ticked.day = c_month ? ccc_pkg::DAY_W'(1) : day_inc[ccc_pkg::DAY_W-1:0];
        end
        if (c_month)
        begin
            ticked.month = c_year ? ccc_pkg::MONTH_W'(1) : month_inc[ccc_pkg::MONTH_W-1:0];
        end
        if (c_year)
        begin
            ticked.year = cur.year + 1'b1;
        end
    end

    always_comb
    begin
        nxt  = cur;
        tick = 1'b0;
        unique case (ccc_pkg::func_t'(func))
            ccc_pkg::FUNC_TICK:
            begin
                nxt  = ticked;
                tick = 1'b1;
            end
            ccc_pkg::FUNC_LOAD_ALL:
            begin
                nxt = load;
            end
            ccc_pkg::FUNC_LOAD_DATE:
            begin
                nxt.day   = load.day;
                nxt.month = load.month;
                nxt.year  = load.year;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    assign res.tm           = nxt;
    assign res.minute_event = tick && adv_min;
    assign res.time_valid   = (nxt.month >= ccc_pkg::MONTH_W'(1))
                           && (nxt.month <= ccc_pkg::MONTHS)
                           && (nxt.day >= ccc_pkg::DAY_W'(1))
                           && (nxt.day <= ccc_pkg::days_in(nxt.month))
                           && (nxt.second <= ccc_pkg::MAX_SECOND)
                           && (nxt.minute <= ccc_pkg::MAX_MINUTE)
                           && (nxt.hour <= ccc_pkg::MAX_HOUR);

endmodule

>>> hw/rtl/calendar_clock_counter.sv
// ============================================================================
// calendar_clock_counter: second-to-year calendar counter, no leap years
// Ticks, full-time loads and date loads in; one time word out per command.
// ============================================================================
// Path: the accepting edge fills the input register (stage 1); once the
//   response slot is free, the word moves into the time/response register.
// Throughput: one request per clock while rsp.ready is high; the carry chain
//   second..year is combinational compare-and-increment logic.
// Reset (rst_n low, async): time 00:00:00, day 1, month 1, year 0;
//   fast_mode cleared; both pipeline stages empty.
// ============================================================================
module calendar_clock_counter (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    ccc_req_if.sink   req,
    ccc_rsp_if.source rsp
);

    // ---- configuration ----
    logic fast_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            fast_mode_reg <= cfg_wdata;
        end
    end

    // ---- stage 1: request register ----
    logic                        s1_valid_reg;
    logic [ccc_pkg::FUNC_W-1:0]  s1_func_reg;
    ccc_pkg::cal_time_t          s1_load_reg;

    // ---- stage 2: time counters double as the response register ----
    logic                        out_valid_reg;
    ccc_pkg::cal_time_t          time_reg;
    logic                        time_valid_reg;
    logic                        event_reg;

    logic                        out_free;   // response slot can take a word
    logic                        s1_move;    // stage 1 word is committed
    ccc_pkg::step_res_t          step_res;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_move   = s1_valid_reg && out_free;
    // Stage 1 refills in the same cycle it drains, so ready stays high
    // under full streaming.
    assign req.ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    // Payload capture, no reset needed.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_func_reg        <= req.func;
            s1_load_reg.second <= req.set_second;
            s1_load_reg.minute <= req.set_minute;
            s1_load_reg.hour   <= req.set_hour;
            s1_load_reg.day    <= req.set_day;
            s1_load_reg.month  <= req.set_month;
            s1_load_reg.year   <= req.set_year;
        end
    end

    ccc_step u_step (
        .cur       (time_reg),
        .fast_mode (fast_mode_reg),
        .func      (s1_func_reg),
        .load      (s1_load_reg),
        .res       (step_res)
    );

    // The calendar only moves when a word is committed to the response slot,
    // so the held response always equals the live counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            time_reg       <= ccc_pkg::RESET_TIME;
            time_valid_reg <= 1'b1;
            event_reg      <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg  <= 1'b1;
            time_reg       <= step_res.tm;
            time_valid_reg <= step_res.time_valid;
            event_reg      <= step_res.minute_event;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.cur_second   = time_reg.second;
    assign rsp.cur_minute   = time_reg.minute;
    assign rsp.cur_hour     = time_reg.hour;
    assign rsp.cur_day      = time_reg.day;
    assign rsp.cur_month    = time_reg.month;
    assign rsp.cur_year     = time_reg.year;
    assign rsp.time_valid   = time_valid_reg;
    assign rsp.minute_event = event_reg;

    // ---- checks ----
    a_time_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_move |=> $stable(time_reg))
        else $error("time changed without a committed word");

    a_event_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && (s1_func_reg != ccc_pkg::FUNC_TICK) |=> !event_reg)
        else $error("minute event on a non-tick command");

    a_valid_means_legal: assert property (@(posedge clk) disable iff (!rst_n)
        time_valid_reg |-> (time_reg.month >= ccc_pkg::MONTH_W'(1))
                        && (time_reg.month <= ccc_pkg::MONTHS)
                        && (time_reg.second <= ccc_pkg::MAX_SECOND)
                        && (time_reg.hour <= ccc_pkg::MAX_HOUR))
        else $error("time flagged valid but out of range");

    a_slow_event_zero_sec: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && !fast_mode_reg |=> !event_reg || (time_reg.second == '0))
        else $error("minute event in normal mode without second rollover");

endmodule
